### design/track_association_table_assert.svh
// Assertion macros for the track association table.
`ifndef TRACK_ASSOCIATION_TABLE_ASSERT_SVH
`define TRACK_ASSOCIATION_TABLE_ASSERT_SVH
`define TAT_ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define TAT_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

### design/tat_pkg.sv
// Shared types and constants for the track association table.
`default_nettype none
package tat_pkg;
	localparam int unsigned ID_W = 4;
	localparam logic [15:0] HIT_MASK = 16'hFFFF;
	localparam logic [15:0] FRAME_LIMIT = 16'hFFFF;
	localparam logic [7:0] MISS_SAT = 8'd255;
	localparam logic [1:0] REG_GATE = 2'd0;
	localparam logic [1:0] REG_MISS = 2'd1;
	localparam logic [1:0] REG_BUILD = 2'd2;
	localparam logic [1:0] REG_AREA = 2'd3;

	typedef struct packed {
		logic [13:0] az;
		logic [13:0] el;
		logic [13:0] row;
		logic [13:0] col;
		logic [15:0] area;
	} feat_t;

	typedef struct packed {
		logic [15:0] gate_distance;
		logic [7:0] miss_limit;
		logic [7:0] build_frames;
		logic [15:0] area_initial;
	} cfg_t;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_SEED  = 12'b000000000010,
		S_CLR   = 12'b000000000100,
		S_CRD   = 12'b000000001000,
		S_CMP   = 12'b000000010000,
		S_ADD   = 12'b000000100000,
		S_UPD   = 12'b000001000000,
		S_EMIT  = 12'b000010000000,
		S_LOST  = 12'b000100000000,
		S_DEL   = 12'b001000000000,
		S_RCY   = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	function automatic logic [14:0] adiff14(input logic [13:0] a, input logic [13:0] b);
		adiff14 = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
	endfunction

	function automatic logic [15:0] adiff16(input logic [15:0] a, input logic [15:0] b);
		adiff16 = (a > b) ? a - b : b - a;
	endfunction
endpackage
`default_nettype wire

### design/tat_cfg.sv
// Configuration register file of the track association table.
`default_nettype none
module tat_cfg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output tat_pkg::cfg_t           cfg
);
	tat_pkg::cfg_t cfg_q;
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_distance <= 16'd160;
			cfg_q.miss_limit <= 8'd5;
			cfg_q.build_frames <= 8'd10;
			cfg_q.area_initial <= 16'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				tat_pkg::REG_GATE: cfg_q.gate_distance <= cfg_data;
				tat_pkg::REG_MISS: cfg_q.miss_limit <= cfg_data[7:0];
				tat_pkg::REG_BUILD: cfg_q.build_frames <= cfg_data[7:0];
				tat_pkg::REG_AREA: cfg_q.area_initial <= cfg_data;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/track_association_table.sv
// Top level of the track association table: sequencer, track table and candidate buffer.
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall | operation, positions, area
//  out     | output    | out_valid/out_stall | track result
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// A detection transfer is taken while the sequencer is idle. At an end of frame the
// single compare unit visits each track in turn for each of the C buffered detections,
// with T tracks, and then each matched track is updated.
// Each deleted track adds a search of the tracks by hits and a shift of the table.
// Reset empties the table at once; the input is stalled while a frame is processed
// and the sequencer waits to load the output register while it is full and stalled.
`default_nettype none
module track_association_table #(
	parameter int unsigned MAX_TRACKS = 16,
	parameter int unsigned MAX_CANDIDATES = 32,
	parameter int unsigned ID_COUNT = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [13:0] azimuth_pos,
	input  wire logic [13:0] elevation_pos,
	input  wire logic [13:0] image_row,
	input  wire logic [13:0] image_col,
	input  wire logic [15:0] blob_area,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             track_valid,
	output logic [3:0]       track_id,
	output logic [13:0]      out_row,
	output logic [13:0]      out_col,
	output logic [15:0]      out_area,
	output logic [15:0]      hit_count,
	output logic             last_of_frame,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int unsigned TW = $clog2(MAX_TRACKS);
	localparam int unsigned TCW = $clog2(MAX_TRACKS + 1);
	localparam int unsigned CW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int unsigned CCW = $clog2(MAX_CANDIDATES + 1);
	localparam int unsigned QW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int unsigned QCW = $clog2(ID_COUNT + 1);

	tat_pkg::cfg_t cfg;
	tat_cfg u_cfg (.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg);

	tat_pkg::feat_t cand_mem [MAX_CANDIDATES];
	tat_pkg::feat_t cand_rd_q;
	logic [CW-1:0] cand_ra;

	tat_pkg::feat_t feat_q [MAX_TRACKS];
	logic [15:0] hits_q [MAX_TRACKS];
	logic [7:0] miss_q [MAX_TRACKS];
	logic [17:0] dx_q [MAX_TRACKS];
	logic [17:0] dy_q [MAX_TRACKS];
	logic [13:0] lrow_q [MAX_TRACKS];
	logic [13:0] lcol_q [MAX_TRACKS];
	logic hit_q [MAX_TRACKS];
	logic [15:0] best_q [MAX_TRACKS];
	logic [CW-1:0] pick_q [MAX_TRACKS];
	logic [3:0] ident_q [MAX_TRACKS];
	logic [3:0] fq_q [ID_COUNT];

	logic [QCW-1:0] qcnt_q;
	logic [3:0] hid_q;
	logic [TCW-1:0] tcnt_q, n0_q;
	logic [16:0] frame_q;
	logic [CCW-1:0] ccnt_q;
	tat_pkg::state_t st_q;
	logic [CCW-1:0] ci_q;
	logic [TCW-1:0] j_q, k_q;
	logic gated_q, any_q;
	logic [15:0] most_q;
	logic [TCW-1:0] sel_q;
	logic [3:0] rid_q;
	logic ov_q;
	logic [3:0] stg_id_q;
	logic [13:0] stg_row_q;
	logic [13:0] stg_col_q;
	logic [15:0] stg_area_q;
	logic [15:0] stg_hits_q;

	logic [15:0] l1_sum;
	logic [15:0] ad;
	logic [TW-1:0] jx, kx;
	logic [3:0] nid;
	logic [15:0] hnext;
	logic out_free;
	logic ov_load;

	assign jx = j_q[TW-1:0];
	assign kx = k_q[TW-1:0];
	assign cand_ra = ci_q[CW-1:0];
	assign l1_sum = {1'b0, tat_pkg::adiff14(cand_rd_q.az, feat_q[jx].az)} +
		{1'b0, tat_pkg::adiff14(cand_rd_q.el, feat_q[jx].el)};
	assign ad = tat_pkg::adiff16(cand_rd_q.area, feat_q[jx].area);
	assign hnext = hits_q[jx] + 16'd1;
	always_comb begin
		if (qcnt_q != '0) nid = fq_q[0];
		else if (hid_q < 4'(ID_COUNT)) nid = hid_q + 4'd1;
		else nid = 4'd0;
	end

	assign in_stall = (st_q != tat_pkg::S_IDLE);
	assign out_valid = ov_q;
	assign out_free = !ov_q || !out_stall;
	assign ov_load = ((st_q == tat_pkg::S_EMIT) && gated_q && any_q && out_free) ||
		((st_q == tat_pkg::S_DONE) && out_free);

	always_ff @(posedge clk) begin
		if (st_q == tat_pkg::S_IDLE && in_valid && !operation && ccnt_q < CCW'(MAX_CANDIDATES))
			cand_mem[ccnt_q[CW-1:0]] <= '{azimuth_pos, elevation_pos, image_row, image_col,
				blob_area};
		cand_rd_q <= cand_mem[cand_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tat_pkg::S_IDLE;
			qcnt_q <= '0; hid_q <= '0; tcnt_q <= '0; n0_q <= '0;
			frame_q <= '0; ccnt_q <= '0; ci_q <= '0; j_q <= '0; k_q <= '0;
			gated_q <= 1'b0; any_q <= 1'b0; most_q <= '0; sel_q <= '0; rid_q <= '0;
			ov_q <= 1'b0;
			stg_id_q <= '0; stg_row_q <= '0; stg_col_q <= '0; stg_area_q <= '0;
			stg_hits_q <= '0;
			track_valid <= 1'b0; track_id <= '0; out_row <= '0; out_col <= '0;
			out_area <= '0; hit_count <= '0; last_of_frame <= 1'b0;
			for (int t = 0; t < MAX_TRACKS; t++) begin
				hits_q[t] <= '0; miss_q[t] <= '0; dx_q[t] <= '0; dy_q[t] <= '0;
				lrow_q[t] <= '0; lcol_q[t] <= '0; hit_q[t] <= 1'b0; best_q[t] <= '0;
				pick_q[t] <= '0; ident_q[t] <= '0; feat_q[t] <= '0;
			end
			for (int q = 0; q < ID_COUNT; q++) fq_q[q] <= '0;
		end else begin
			if (ov_load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			case (st_q)
				tat_pkg::S_IDLE: begin
					if (in_valid) begin
						if (!operation) begin
							if (ccnt_q < CCW'(MAX_CANDIDATES)) ccnt_q <= ccnt_q + 1'b1;
						end else begin
							logic [16:0] f;
							f = frame_q + ((ccnt_q != '0) ? 17'd1 : 17'd0);
							frame_q <= f;
							ci_q <= '0; j_q <= '0; any_q <= 1'b0;
							n0_q <= tcnt_q;
							if (f <= {9'd0, cfg.build_frames} && f == 17'd1) begin
								st_q <= (tcnt_q == '0) ? tat_pkg::S_SEED : tat_pkg::S_DONE;
							end else st_q <= tat_pkg::S_CLR;
						end
					end
				end
				tat_pkg::S_SEED: begin
					// The candidate read is registered: alternate address and write.
					if (ci_q >= ccnt_q || tcnt_q >= TCW'(MAX_TRACKS)) st_q <= tat_pkg::S_DONE;
					else if (!gated_q) gated_q <= 1'b1;
					else begin
						gated_q <= 1'b0;
						feat_q[tcnt_q[TW-1:0]] <= cand_rd_q;
						hits_q[tcnt_q[TW-1:0]] <= '0; miss_q[tcnt_q[TW-1:0]] <= '0;
						dx_q[tcnt_q[TW-1:0]] <= '0; dy_q[tcnt_q[TW-1:0]] <= '0;
						lrow_q[tcnt_q[TW-1:0]] <= '0; lcol_q[tcnt_q[TW-1:0]] <= '0;
						hit_q[tcnt_q[TW-1:0]] <= 1'b0;
						best_q[tcnt_q[TW-1:0]] <= cfg.area_initial;
						pick_q[tcnt_q[TW-1:0]] <= '0;
						if (hid_q < 4'(ID_COUNT)) begin
							hid_q <= hid_q + 4'd1; ident_q[tcnt_q[TW-1:0]] <= hid_q + 4'd1;
						end else ident_q[tcnt_q[TW-1:0]] <= 4'd0;
						tcnt_q <= tcnt_q + 1'b1;
						ci_q <= ci_q + 1'b1;
					end
				end
				tat_pkg::S_CLR: begin
					if (j_q >= n0_q) begin
						j_q <= '0; st_q <= tat_pkg::S_CRD;
					end else begin
						hit_q[jx] <= 1'b0; best_q[jx] <= cfg.area_initial; pick_q[jx] <= '0;
						j_q <= j_q + 1'b1;
					end
				end
				tat_pkg::S_CRD: begin
					j_q <= '0; gated_q <= 1'b0;
					st_q <= (ci_q >= ccnt_q) ? tat_pkg::S_UPD : tat_pkg::S_CMP;
				end
				tat_pkg::S_CMP: begin
					if (j_q >= n0_q) st_q <= tat_pkg::S_ADD;
					else begin
						if (l1_sum < cfg.gate_distance) begin
							gated_q <= 1'b1;
							if (ad < best_q[jx]) begin
								best_q[jx] <= ad; hit_q[jx] <= 1'b1; pick_q[jx] <= cand_ra;
							end
						end
						j_q <= j_q + 1'b1;
					end
				end
				tat_pkg::S_ADD: begin
					if (!gated_q && tcnt_q < TCW'(MAX_TRACKS)) begin
						feat_q[tcnt_q[TW-1:0]] <= cand_rd_q;
						hits_q[tcnt_q[TW-1:0]] <= '0; miss_q[tcnt_q[TW-1:0]] <= '0;
						dx_q[tcnt_q[TW-1:0]] <= '0; dy_q[tcnt_q[TW-1:0]] <= '0;
						lrow_q[tcnt_q[TW-1:0]] <= '0; lcol_q[tcnt_q[TW-1:0]] <= '0;
						hit_q[tcnt_q[TW-1:0]] <= 1'b0;
						best_q[tcnt_q[TW-1:0]] <= cfg.area_initial;
						pick_q[tcnt_q[TW-1:0]] <= '0;
						ident_q[tcnt_q[TW-1:0]] <= nid;
						if (qcnt_q != '0) begin
							for (int q = 0; q + 1 < ID_COUNT; q++) fq_q[q] <= fq_q[q+1];
							qcnt_q <= qcnt_q - 1'b1;
						end else if (hid_q < 4'(ID_COUNT)) hid_q <= hid_q + 4'd1;
						tcnt_q <= tcnt_q + 1'b1;
					end
					ci_q <= ci_q + 1'b1;
					j_q <= '0;
					st_q <= tat_pkg::S_CRD;
				end
				tat_pkg::S_UPD: begin
					if (j_q >= tcnt_q) begin
						j_q <= '0;
						st_q <= (frame_q > {9'd0, cfg.build_frames}) ? tat_pkg::S_LOST
							: tat_pkg::S_DONE;
					end else if (!hit_q[jx]) j_q <= j_q + 1'b1;
					else begin
						ci_q <= CCW'(pick_q[jx]);
						gated_q <= 1'b0;
						st_q <= tat_pkg::S_EMIT;
					end
				end
				tat_pkg::S_EMIT: begin
					if (!gated_q) gated_q <= 1'b1;
					else if (!any_q || out_free) begin
						// The newest result waits in the staging register until the next
						// one or the frame end shows whether it is the last transfer.
						feat_q[jx] <= cand_rd_q;
						hits_q[jx] <= hnext;
						dx_q[jx] <= dx_q[jx] + 18'(cand_rd_q.col) - 18'(lcol_q[jx]);
						dy_q[jx] <= dy_q[jx] + 18'(cand_rd_q.row) - 18'(lrow_q[jx]);
						lcol_q[jx] <= cand_rd_q.col; lrow_q[jx] <= cand_rd_q.row;
						if (any_q) begin
							track_valid <= 1'b1; track_id <= stg_id_q;
							out_row <= stg_row_q; out_col <= stg_col_q;
							out_area <= stg_area_q; hit_count <= stg_hits_q;
							last_of_frame <= 1'b0;
						end
						any_q <= 1'b1;
						stg_id_q <= ident_q[jx];
						stg_row_q <= cand_rd_q.row; stg_col_q <= cand_rd_q.col;
						stg_area_q <= cand_rd_q.area; stg_hits_q <= hnext;
						j_q <= j_q + 1'b1;
						st_q <= tat_pkg::S_UPD;
					end
				end
				tat_pkg::S_LOST: begin
					if (j_q >= tcnt_q) st_q <= tat_pkg::S_DONE;
					else begin
						logic [7:0] m;
						m = hit_q[jx] ? 8'd0 : ((miss_q[jx] < tat_pkg::MISS_SAT) ?
							miss_q[jx] + 8'd1 : miss_q[jx]);
						miss_q[jx] <= m;
						if (m >= cfg.miss_limit) begin
							rid_q <= ident_q[jx];
							k_q <= '0; most_q <= '0; sel_q <= TCW'(MAX_TRACKS);
							st_q <= tat_pkg::S_DEL;
						end else j_q <= j_q + 1'b1;
					end
				end
				tat_pkg::S_DEL: begin
					// Search the unnumbered track with most hits, one track a cycle.
					if (k_q >= tcnt_q) begin
						if (rid_q != 4'd0) begin
							if (sel_q != TCW'(MAX_TRACKS)) ident_q[sel_q[TW-1:0]] <= rid_q;
							else if (qcnt_q < QCW'(ID_COUNT)) begin
								fq_q[qcnt_q[QW-1:0]] <= rid_q; qcnt_q <= qcnt_q + 1'b1;
							end
						end
						k_q <= j_q;
						st_q <= tat_pkg::S_RCY;
					end else begin
						if (ident_q[kx] == 4'd0 && hits_q[kx] > most_q) begin
							most_q <= hits_q[kx]; sel_q <= k_q;
						end
						k_q <= k_q + 1'b1;
					end
				end
				tat_pkg::S_RCY: begin
					if (k_q + 1'b1 < tcnt_q) begin
						feat_q[kx] <= feat_q[kx+1'b1]; hits_q[kx] <= hits_q[kx+1'b1];
						miss_q[kx] <= miss_q[kx+1'b1]; dx_q[kx] <= dx_q[kx+1'b1];
						dy_q[kx] <= dy_q[kx+1'b1]; lrow_q[kx] <= lrow_q[kx+1'b1];
						lcol_q[kx] <= lcol_q[kx+1'b1]; hit_q[kx] <= hit_q[kx+1'b1];
						best_q[kx] <= best_q[kx+1'b1]; pick_q[kx] <= pick_q[kx+1'b1];
						ident_q[kx] <= ident_q[kx+1'b1];
						k_q <= k_q + 1'b1;
					end else begin
						tcnt_q <= tcnt_q - 1'b1;
						if (tcnt_q == TCW'(1)) begin
							frame_q <= '0; hid_q <= '0; qcnt_q <= '0;
						end
						st_q <= tat_pkg::S_LOST;
					end
				end
				tat_pkg::S_DONE: begin
					if (out_free) begin
						if (frame_q > {1'b0, tat_pkg::FRAME_LIMIT})
							frame_q <= {9'd0, cfg.build_frames} + 17'd1;
						ccnt_q <= '0;
						gated_q <= 1'b0;
						any_q <= 1'b0;
						if (any_q) begin
							track_valid <= 1'b1; track_id <= stg_id_q;
							out_row <= stg_row_q; out_col <= stg_col_q;
							out_area <= stg_area_q; hit_count <= stg_hits_q;
						end else begin
							track_valid <= 1'b0; track_id <= '0; out_row <= '0; out_col <= '0;
							out_area <= '0; hit_count <= '0;
						end
						last_of_frame <= 1'b1;
						st_q <= tat_pkg::S_IDLE;
					end
				end
				default: st_q <= tat_pkg::S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/tat_checker.sv
// Port-level checker for the track association table, bound to the top level.
`default_nettype none
`include "track_association_table_assert.svh"
module tat_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic operation,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic track_valid,
	input wire logic last_of_frame,
	input wire logic [3:0] track_id
);
	`TAT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`TAT_ASSERT_IMPL(a_empty_last, out_valid && !track_valid, last_of_frame && track_id == 4'd0)
	`TAT_ASSERT_NEXT(a_eof_busy, in_valid && !in_stall && operation, in_stall)
	`TAT_ASSERT_IMPL(a_id_range, out_valid, track_id <= 4'd15)
endmodule
bind track_association_table tat_checker u_tat_checker (
	.clk, .arst_n, .in_valid, .in_stall, .operation, .out_valid, .out_stall,
	.track_valid, .last_of_frame, .track_id
);
`default_nettype wire

### sim/track_association_checker.sv
// Checker for the track association table: predicts results from accepted transfers and compares.
module track_association_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        operation,
	input  wire logic [13:0] azimuth_pos,
	input  wire logic [13:0] elevation_pos,
	input  wire logic [13:0] image_row,
	input  wire logic [13:0] image_col,
	input  wire logic [15:0] blob_area,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        track_valid,
	input  wire logic [3:0]  track_id,
	input  wire logic [13:0] out_row,
	input  wire logic [13:0] out_col,
	input  wire logic [15:0] out_area,
	input  wire logic [15:0] hit_count,
	input  wire logic        last_of_frame,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output int               fails,
	output int               pending
);
	localparam int NTRK = 16;
	localparam int NCAND = 32;
	localparam int NID = 10;

	typedef struct packed {
		logic        valid;
		logic [3:0]  id;
		logic [13:0] row;
		logic [13:0] col;
		logic [15:0] area;
		logic [15:0] hits;
		logic        last;
	} track_result_t;

	track_result_t expected_tracks[$];
	tat_pkg::cfg_t cfg;
	tat_pkg::feat_t trk_feat[NTRK];
	logic [15:0] trk_hits[NTRK];
	logic [7:0] trk_miss[NTRK];
	logic [3:0] trk_id[NTRK];
	logic trk_hit[NTRK];
	logic [15:0] trk_best[NTRK];
	int trk_pick[NTRK];
	tat_pkg::feat_t cand[NCAND];
	logic [3:0] free_q[NID];
	int trk_n, cand_n, q_n, hi_id, frame_cnt;

	assign pending = expected_tracks.size();

	function automatic int absdiff(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic logic [3:0] take_id();
		logic [3:0] id;
		if (q_n > 0) begin
			id = free_q[0];
			for (int k = 0; k + 1 < q_n; k++)
				free_q[k] = free_q[k + 1];
			q_n--;
			return id;
		end
		if (hi_id < NID) begin
			hi_id++;
			return hi_id[3:0];
		end
		return 4'd0;
	endfunction

	task automatic add_track(input tat_pkg::feat_t f, input logic [3:0] id);
		if (trk_n < NTRK) begin
			trk_feat[trk_n] = f;
			trk_hits[trk_n] = '0;
			trk_miss[trk_n] = '0;
			trk_hit[trk_n] = 1'b0;
			trk_best[trk_n] = cfg.area_initial;
			trk_pick[trk_n] = 0;
			trk_id[trk_n] = id;
			trk_n++;
		end
	endtask

	task automatic remove_track(input int p);
		for (int k = p; k + 1 < trk_n; k++) begin
			trk_feat[k] = trk_feat[k + 1];
			trk_hits[k] = trk_hits[k + 1];
			trk_miss[k] = trk_miss[k + 1];
			trk_hit[k] = trk_hit[k + 1];
			trk_best[k] = trk_best[k + 1];
			trk_pick[k] = trk_pick[k + 1];
			trk_id[k] = trk_id[k + 1];
		end
		trk_n--;
		if (trk_n == 0) begin
			frame_cnt = 0;
			hi_id = 0;
			q_n = 0;
		end
	endtask

	task automatic hand_over_id(input logic [3:0] id);
		int most, sel;
		most = 0;
		sel = -1;
		if (id == 0)
			return;
		for (int k = 0; k < trk_n; k++)
			if (trk_id[k] == 0 && trk_hits[k] > most) begin
				most = trk_hits[k];
				sel = k;
			end
		if (sel >= 0)
			trk_id[sel] = id;
		else if (q_n < NID) begin
			free_q[q_n] = id;
			q_n++;
		end
	endtask

	task automatic match_frame(ref track_result_t batch[$]);
		int n0, d;
		logic gated;
		track_result_t r;
		n0 = trk_n;
		for (int j = 0; j < n0; j++) begin
			trk_hit[j] = 1'b0;
			trk_best[j] = cfg.area_initial;
			trk_pick[j] = 0;
		end
		for (int i = 0; i < cand_n; i++) begin
			gated = 1'b0;
			for (int j = 0; j < n0; j++) begin
				d = absdiff(cand[i].az, trk_feat[j].az) + absdiff(cand[i].el, trk_feat[j].el);
				if (d < cfg.gate_distance) begin
					gated = 1'b1;
					if (absdiff(cand[i].area, trk_feat[j].area) < trk_best[j]) begin
						trk_best[j] = absdiff(cand[i].area, trk_feat[j].area);
						trk_hit[j] = 1'b1;
						trk_pick[j] = i;
					end
				end
			end
			if (!gated && trk_n < NTRK)
				add_track(cand[i], take_id());
		end
		for (int j = 0; j < trk_n; j++) begin
			if (trk_hit[j]) begin
				trk_feat[j] = cand[trk_pick[j]];
				trk_hits[j] = trk_hits[j] + 16'd1;
				r = '{1'b1, trk_id[j], trk_feat[j].row, trk_feat[j].col,
					trk_feat[j].area, trk_hits[j], 1'b0};
				batch.push_back(r);
			end
		end
	endtask

	task automatic age_tracks();
		int j;
		j = 0;
		while (j < trk_n) begin
			if (trk_hit[j])
				trk_miss[j] = '0;
			else if (trk_miss[j] < tat_pkg::MISS_SAT)
				trk_miss[j]++;
			if (trk_miss[j] >= cfg.miss_limit) begin
				hand_over_id(trk_id[j]);
				remove_track(j);
			end else begin
				j++;
			end
		end
	endtask

	task automatic predict_item(input logic op, input tat_pkg::feat_t f);
		track_result_t batch[$];
		if (!op) begin
			if (cand_n < NCAND) begin
				cand[cand_n] = f;
				cand_n++;
			end
			return;
		end
		if (cand_n > 0)
			frame_cnt++;
		if (frame_cnt <= cfg.build_frames) begin
			if (frame_cnt == 1) begin
				if (trk_n == 0)
					for (int i = 0; i < cand_n && trk_n < NTRK; i++)
						add_track(cand[i], (hi_id < NID) ? take_id() : 4'd0);
			end else begin
				match_frame(batch);
			end
		end else begin
			match_frame(batch);
			age_tracks();
			if (frame_cnt > tat_pkg::FRAME_LIMIT)
				frame_cnt = cfg.build_frames + 1;
		end
		cand_n = 0;
		if (batch.size() == 0)
			batch.push_back('{1'b0, 4'd0, 14'd0, 14'd0, 16'd0, 16'd0, 1'b1});
		else
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			expected_tracks.push_back(batch[k]);
	endtask

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		track_result_t e;
		if (!arst_n) begin
			cfg = '{16'd160, 8'd5, 8'd10, 16'd1000};
			trk_n = 0;
			cand_n = 0;
			q_n = 0;
			hi_id = 0;
			frame_cnt = 0;
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tat_pkg::REG_GATE: cfg.gate_distance = cfg_data;
					tat_pkg::REG_MISS: cfg.miss_limit = cfg_data[7:0];
					tat_pkg::REG_BUILD: cfg.build_frames = cfg_data[7:0];
					tat_pkg::REG_AREA: cfg.area_initial = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_item(operation, '{azimuth_pos, elevation_pos, image_row, image_col,
					blob_area});
			if (out_valid && !out_stall) begin
				if (expected_tracks.size() == 0) begin
					report("unexpected result, track_id", {12'd0, track_id}, 16'd0);
				end else begin
					e = expected_tracks.pop_front();
					if (track_valid !== e.valid) report("track_valid", track_valid, e.valid);
					if (track_id !== e.id) report("track_id", track_id, e.id);
					if (out_row !== e.row) report("out_row", out_row, e.row);
					if (out_col !== e.col) report("out_col", out_col, e.col);
					if (out_area !== e.area) report("out_area", out_area, e.area);
					if (hit_count !== e.hits) report("hit_count", hit_count, e.hits);
					if (last_of_frame !== e.last)
						report("last_of_frame", last_of_frame, e.last);
				end
			end
		end
	end
endmodule

### sim/testbench.sv
// Top of the track association table testbench: clock, reset, stimulus and verdict.
module testbench;
	localparam int WATCHDOG = 20000;
	localparam int SETTLE = 600;
	localparam int NTGT = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = 1'b0;
	logic [13:0] azimuth_pos = '0;
	logic [13:0] elevation_pos = '0;
	logic [13:0] image_row = '0;
	logic [13:0] image_col = '0;
	logic [15:0] blob_area = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic track_valid;
	logic [3:0] track_id;
	logic [13:0] out_row;
	logic [13:0] out_col;
	logic [15:0] out_area;
	logic [15:0] hit_count;
	logic last_of_frame;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int fails, pending;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet = 0;
	int phase_items;
	int tgt_az[NTGT], tgt_el[NTGT], tgt_area[NTGT];

	track_association_table dut (.*);
	track_association_checker chk (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seq != hold_seen) begin
			out_stall <= 1'b1;
			hold_seen <= hold_seq;
			hold_left <= 700;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == WATCHDOG) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic send(input logic op, input int az, input int el, input int row,
		input int col, input int area);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		operation = op;
		azimuth_pos = az[13:0];
		elevation_pos = el[13:0];
		image_row = row[13:0];
		image_col = col[13:0];
		blob_area = area[15:0];
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
		phase_items++;
	endtask

	task automatic end_frame();
		send(1'b1, $urandom_range(16383), $urandom_range(16383), $urandom_range(16383),
			$urandom_range(16383), $urandom_range(65535));
	endtask

	task automatic send_noise();
		send(1'b0, $urandom_range(16383), $urandom_range(16383), $urandom_range(16383),
			$urandom_range(16383), $urandom_range(65535));
	endtask

	task automatic send_near(input int t);
		send(1'b0, tgt_az[t] + $urandom_range(40) - 20, tgt_el[t] + $urandom_range(40) - 20,
			$urandom_range(16383), $urandom_range(16383), tgt_area[t] + $urandom_range(80) - 40);
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input int gate, input int miss, input int build, input int area);
		write_reg(tat_pkg::REG_GATE, gate[15:0]);
		write_reg(tat_pkg::REG_MISS, miss[15:0]);
		write_reg(tat_pkg::REG_BUILD, build[15:0]);
		write_reg(tat_pkg::REG_AREA, area[15:0]);
	endtask

	task automatic random_frames(input int quota, input logic pressure);
		int nd;
		logic held, drained;
		held = 1'b0;
		drained = 1'b0;
		phase_items = 0;
		while (phase_items < quota) begin
			if (pressure && !held && phase_items > 8) begin
				hold_seq++;
				held = 1'b1;
			end
			if (pressure && !drained && phase_items > 20) begin
				drain();
				drained = 1'b1;
			end
			for (int t = 0; t < NTGT; t++) begin
				tgt_az[t] = tgt_az[t] + $urandom_range(10) - 5;
				tgt_el[t] = tgt_el[t] + $urandom_range(10) - 5;
			end
			if ($urandom_range(3) == 0) begin
				tgt_az[$urandom_range(NTGT - 1)] = $urandom_range(15000, 1000);
				tgt_el[$urandom_range(NTGT - 1)] = $urandom_range(15000, 1000);
			end
			nd = $urandom_range(5);
			for (int k = 0; k < nd; k++)
				send_near($urandom_range(NTGT - 1));
			if ($urandom_range(4) == 0)
				send_noise();
			end_frame();
		end
	endtask

	initial begin
		for (int t = 0; t < NTGT; t++) begin
			tgt_az[t] = $urandom_range(15000, 1000);
			tgt_el[t] = $urandom_range(15000, 1000);
			tgt_area[t] = $urandom_range(2000, 100);
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		configure(160, 3, 2, 1000);

		// Directed part: empty frame, seeding with extreme fields, gating and unmatched frames.
		end_frame();
		send(1'b0, 0, 0, 0, 0, 0);
		send(1'b0, 16383, 16383, 16383, 16383, 65535);
		send_near(0);
		send_near(1);
		end_frame();
		send(1'b0, 5, 5, 16383, 0, 10);
		send(1'b0, 16380, 16380, 0, 16383, 65530);
		send_near(0);
		send(1'b0, tgt_az[0], tgt_el[0], 100, 200, tgt_area[0] + 2000);
		end_frame();
		end_frame();
		send_near(1);
		end_frame();
		end_frame();
		send_near(1);
		end_frame();
		drain();

		random_frames(32, 1'b1);
		drain();

		send_idle_pct = 48;
		configure(65535, 255, 255, 65535);
		random_frames(32, 1'b0);
		drain();

		send_idle_pct = 0;
		stall_pct = 48;
		configure(0, 1, 1, 0);
		random_frames(28, 1'b0);
		drain();

		send_idle_pct = 6;
		stall_pct = 6;
		configure(300, 4, 1, 2000);
		for (int k = 0; k < 34; k++)
			send_noise();
		end_frame();
		random_frames(26, 1'b0);
		drain();

		if (fails == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
